/* sv/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is high.
`define CTS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that also holds across reset.
`define CTS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/cts_pkg.sv */
// Types, token codes and character tables for the C token scanner.
package cts_pkg;

  localparam int KW_MAX_LEN = 8;
  localparam int REC_MAX    = 3;

  localparam logic [6:0] K_BAD      = 7'd0;
  localparam logic [6:0] K_PERIOD   = 7'd5;
  localparam logic [6:0] K_ELLIPSIS = 7'd6;
  localparam logic [6:0] K_SHL_EQ   = 7'd27;
  localparam logic [6:0] K_SHL      = 7'd28;
  localparam logic [6:0] K_SHR_EQ   = 7'd31;
  localparam logic [6:0] K_SHR      = 7'd32;
  localparam logic [6:0] K_WS       = 7'd49;
  localparam logic [6:0] K_COMMENT  = 7'd50;
  localparam logic [6:0] K_IDENT    = 7'd51;
  localparam logic [6:0] K_KW0      = 7'd52;
  localparam logic [6:0] K_DEC      = 7'd84;
  localparam logic [6:0] K_OCT      = 7'd85;
  localparam logic [6:0] K_HEX      = 7'd86;
  localparam logic [6:0] K_FLT      = 7'd87;
  localparam logic [6:0] K_CHR      = 7'd88;
  localparam logic [6:0] K_STR      = 7'd89;

  localparam logic [7:0] PAIR_MORE  = 8'd255;

  localparam logic [2:0] D_NONE      = 3'd0;
  localparam logic [2:0] D_ILLEGAL   = 3'd1;
  localparam logic [2:0] D_EMPTY_EXP = 3'd2;
  localparam logic [2:0] D_EMPTY_HEX = 3'd3;
  localparam logic [2:0] D_BAD_ESC   = 3'd4;
  localparam logic [2:0] D_OPEN_CHR  = 3'd5;
  localparam logic [2:0] D_OPEN_STR  = 3'd6;
  localparam logic [2:0] D_OPEN_CMT  = 3'd7;

  // number flag bits
  localparam logic [3:0] NF_LEAD0 = 4'd1;
  localparam logic [3:0] NF_ONE   = 4'd2;
  localparam logic [3:0] NF_SPLIT = 4'd4;
  localparam logic [3:0] NF_LONG  = 4'd1;
  localparam logic [3:0] NF_UNS   = 4'd2;
  localparam logic [3:0] NF_DIGIT = 4'd1;

  typedef enum logic [25:0] {
    S_IDLE      = 26'd1 << 0,
    S_WS        = 26'd1 << 1,
    S_IDENT     = 26'd1 << 2,
    S_LPRE      = 26'd1 << 3,
    S_P1        = 26'd1 << 4,
    S_P2        = 26'd1 << 5,
    S_DOT1      = 26'd1 << 6,
    S_DOT2      = 26'd1 << 7,
    S_CMT       = 26'd1 << 8,
    S_CMT_STAR  = 26'd1 << 9,
    S_NUM       = 26'd1 << 10,
    S_HEX       = 26'd1 << 11,
    S_SUF       = 26'd1 << 12,
    S_FRAC      = 26'd1 << 13,
    S_EXPA_SIGN = 26'd1 << 14,
    S_EXPA_DIG  = 26'd1 << 15,
    S_AFTER_A   = 26'd1 << 16,
    S_EXPB_SIGN = 26'd1 << 17,
    S_EXPB_DIG  = 26'd1 << 18,
    S_FSUF      = 26'd1 << 19,
    S_CH_OPEN   = 26'd1 << 20,
    S_CH_CLOSE  = 26'd1 << 21,
    S_STR       = 26'd1 << 22,
    S_ESC       = 26'd1 << 23,
    S_ESC_OCT   = 26'd1 << 24,
    S_ESC_HEX   = 26'd1 << 25
  } mode_t;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] held;
    logic [3:0] ilen;
    logic [2:0] diag;
    logic [3:0] nflags;
    logic [1:0] esc_cnt;
    logic [6:0] pend_kind;
    logic       esc_str;
  } scan_st_t;

  typedef struct packed {
    logic [6:0]  kind;
    logic [31:0] start_off;
    logic [31:0] end_off;
    logic [2:0]  diag;
    logic        last;
  } rec_t;

  typedef struct packed {
    logic [1:0]           cnt;
    rec_t [REC_MAX-1:0]   recs;
  } bundle_t;

  localparam logic [63:0] KW_TXT [32] = '{
    "auto", "break", "case", "char", "const", "continue", "default", "do",
    "double", "else", "enum", "extern", "float", "for", "goto", "if",
    "int", "long", "register", "return", "short", "signed", "sizeof",
    "static", "struct", "switch", "typedef", "union", "unsigned", "void",
    "volatile", "while"
  };

  localparam logic [3:0] KW_LEN [32] = '{
    4'd4, 4'd5, 4'd4, 4'd4, 4'd5, 4'd8, 4'd7, 4'd2,
    4'd6, 4'd4, 4'd4, 4'd6, 4'd5, 4'd3, 4'd4, 4'd2,
    4'd3, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd6,
    4'd6, 4'd6, 4'd6, 4'd7, 4'd5, 4'd8, 4'd4,
    4'd8, 4'd5
  };

  function automatic logic [6:0] kw_kind(logic [KW_MAX_LEN-1:0][7:0] ib, logic [3:0] il);
    logic [6:0]  k;
    logic        hit;
    logic [63:0] lit;
    k = K_IDENT;
    for (int i = 0; i < 32; i++) begin
      lit = KW_TXT[i] << (7'd64 - {KW_LEN[i], 3'b000});
      hit = (il == KW_LEN[i]);
      for (int j = 0; j < KW_MAX_LEN; j++) begin
        if ((4'(j) < KW_LEN[i]) && (ib[j] != lit[63 - 8*j -: 8])) hit = 1'b0;
      end
      if (hit) k = K_KW0 + 7'(i);
    end
    return k;
  endfunction

  function automatic logic [6:0] direct_kind(logic [7:0] c);
    unique case (c)
      "[":     return 7'd1;
      "]":     return 7'd2;
      "(":     return 7'd3;
      ")":     return 7'd4;
      "~":     return 7'd19;
      "?":     return 7'd41;
      ":":     return 7'd42;
      ",":     return 7'd43;
      "{":     return 7'd46;
      "}":     return 7'd47;
      ";":     return 7'd48;
      default: return K_BAD;
    endcase
  endfunction

  function automatic logic [6:0] single_kind(logic [7:0] c);
    unique case (c)
      "-":     return 7'd10;
      "+":     return 7'd13;
      "&":     return 7'd16;
      "*":     return 7'd18;
      "!":     return 7'd21;
      "/":     return 7'd23;
      "%":     return 7'd25;
      "<":     return 7'd29;
      ">":     return 7'd33;
      "=":     return 7'd35;
      "^":     return 7'd37;
      "|":     return 7'd40;
      "#":     return 7'd45;
      default: return K_BAD;
    endcase
  endfunction

  function automatic logic [7:0] pair_kind(logic [7:0] a, logic [7:0] b);
    unique case (a)
      "-":     return (b == ">") ? 8'd7 : (b == "-") ? 8'd8 : (b == "=") ? 8'd9 : 8'd0;
      "+":     return (b == "+") ? 8'd11 : (b == "=") ? 8'd12 : 8'd0;
      "&":     return (b == "&") ? 8'd14 : (b == "=") ? 8'd15 : 8'd0;
      "*":     return (b == "=") ? 8'd17 : 8'd0;
      "!":     return (b == "=") ? 8'd20 : 8'd0;
      "/":     return (b == "=") ? 8'd22 : 8'd0;
      "%":     return (b == "=") ? 8'd24 : 8'd0;
      "<":     return (b == "=") ? 8'd26 : (b == "<") ? PAIR_MORE : 8'd0;
      ">":     return (b == "=") ? 8'd30 : (b == ">") ? PAIR_MORE : 8'd0;
      "=":     return (b == "=") ? 8'd34 : 8'd0;
      "^":     return (b == "=") ? 8'd36 : 8'd0;
      "|":     return (b == "|") ? 8'd38 : (b == "=") ? 8'd39 : 8'd0;
      "#":     return (b == "#") ? 8'd44 : 8'd0;
      default: return 8'd0;
    endcase
  endfunction

endpackage

/* sv/cts_in_if.sv */
// Byte input channel: valid/ready handshake with one source byte per item.
interface cts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_input;

  modport source (output valid, char_code, end_of_input, input ready);
  modport sink   (input valid, char_code, end_of_input, output ready);
endinterface

/* sv/cts_out_if.sv */
// Token output channel: valid/ready handshake with one token record per item.
interface cts_out_if;
  logic        valid;
  logic        ready;
  logic [6:0]  token_kind;
  logic [31:0] start_offset;
  logic [31:0] end_offset;
  logic [2:0]  diag_code;
  logic        last_of_run;

  modport source (output valid, token_kind, start_offset, end_offset, diag_code,
                  last_of_run, input ready);
  modport sink   (input valid, token_kind, start_offset, end_offset, diag_code,
                  last_of_run, output ready);
endinterface

/* sv/cts_front.sv */
// Front end: accepts bytes, runs the scanner state machine, builds token bundles.
module cts_front #(
  parameter int OFFSET_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  cts_in_if.sink            bytes,
  input  logic              full,
  output logic              push,
  output cts_pkg::bundle_t  push_data
);
  import cts_pkg::*;

  scan_st_t                      st;
  scan_st_t                      s;
  logic [KW_MAX_LEN-1:0][7:0]    ib;
  logic [KW_MAX_LEN-1:0][7:0]    ib_next;
  logic [OFFSET_BITS-1:0]        ts, ts_next;
  logic [OFFSET_BITS-1:0]        osp, osp_next;
  logic [OFFSET_BITS-1:0]        pos, pos_next;
  logic [OFFSET_BITS-1:0]        nx;
  logic [OFFSET_BITS-1:0]        es, ee;
  logic [OFFSET_BITS+31:0]       wide_s, wide_e;
  logic [6:0]                    ek;
  logic [7:0]                    pk8;
  logic                          em, cons, done;
  logic [1:0]                    cnt;
  bundle_t                       bnd;
  mode_t                         ret;
  logic                          accept;
  logic [7:0]                    b;
  logic                          eoi, bv;
  logic                          dig, oct, hx, alf, wrd, spc, nl, nul;

  assign bytes.ready = !full;
  assign accept      = bytes.valid && !full;
  assign b           = bytes.char_code;
  assign eoi         = bytes.end_of_input;
  assign bv          = !eoi;
  assign nx          = pos + OFFSET_BITS'(1);

  assign dig = bv && (b >= "0") && (b <= "9");
  assign oct = bv && (b >= "0") && (b <= "7");
  assign alf = bv && (((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z")));
  assign hx  = dig || (bv && (((b >= "a") && (b <= "f")) || ((b >= "A") && (b <= "F"))));
  assign wrd = alf || dig || (bv && (b == "_"));
  assign spc = bv && ((b == " ") || (b == 8'h09) || (b == 8'h0A) || (b == 8'h0B) ||
                      (b == 8'h0C) || (b == 8'h0D));
  assign nl  = bv && (b == 8'h0A);
  assign nul = bv && (b == 8'h00);

  always_comb begin
    s        = st;
    ib_next  = ib;
    ts_next  = ts;
    osp_next = osp;
    bnd      = '0;
    cnt      = 2'd0;
    done     = 1'b0;
    em       = 1'b0;
    ek       = K_BAD;
    es       = ts;
    ee       = ts;
    cons     = 1'b1;
    pk8      = 8'd0;
    ret      = S_STR;
    wide_s   = '0;
    wide_e   = '0;
    for (int i = 0; i < 8; i++) begin
      if (!done) begin
        em   = 1'b0;
        cons = 1'b1;
        es   = ts_next;
        ret  = s.esc_str ? S_STR : S_CH_CLOSE;
        pk8  = bv ? pair_kind(s.held, b) : 8'd0;
        unique case (s.mode)
          S_WS: begin
            if (!spc) begin
              em = 1'b1; ek = K_WS; ee = pos; s.mode = S_IDLE; cons = 1'b0;
            end
          end
          S_IDENT: begin
            if (wrd) begin
              if (s.ilen < 4'd8) ib_next[s.ilen[2:0]] = b;
              if (s.ilen <= 4'd8) s.ilen = s.ilen + 4'd1;
            end else begin
              em = 1'b1; ek = kw_kind(ib_next, s.ilen); ee = pos; s.mode = S_IDLE;
              cons = 1'b0;
            end
          end
          S_LPRE: begin
            if (bv && (b == "'")) s.mode = S_CH_OPEN;
            else if (bv && (b == "\"")) s.mode = S_STR;
            else begin
              s.mode = S_IDENT; cons = 1'b0;
            end
          end
          S_P1: begin
            if (bv && (s.held == "/") && (b == "*")) s.mode = S_CMT;
            else if (pk8 == PAIR_MORE) s.mode = S_P2;
            else if (pk8 != 8'd0) begin
              em = 1'b1; ek = pk8[6:0]; ee = nx; s.mode = S_IDLE;
            end else begin
              em = 1'b1; ek = single_kind(s.held); ee = pos; s.mode = S_IDLE;
              cons = 1'b0;
            end
          end
          S_P2: begin
            if (bv && (b == "=")) begin
              em = 1'b1; ek = (s.held == "<") ? K_SHL_EQ : K_SHR_EQ; ee = nx;
              s.mode = S_IDLE;
            end else begin
              em = 1'b1; ek = (s.held == "<") ? K_SHL : K_SHR; ee = pos;
              s.mode = S_IDLE; cons = 1'b0;
            end
          end
          S_DOT1: begin
            if (bv && (b == ".")) s.mode = S_DOT2;
            else if (dig) begin
              s.mode = S_FRAC; cons = 1'b0;
            end else begin
              em = 1'b1; ek = K_PERIOD; ee = pos; s.mode = S_IDLE; cons = 1'b0;
            end
          end
          S_DOT2: begin
            if (bv && (b == ".")) begin
              em = 1'b1; ek = K_ELLIPSIS; ee = nx; s.mode = S_IDLE;
            end else begin
              em = 1'b1; ek = K_PERIOD; ee = ts_next + OFFSET_BITS'(1);
              ts_next = ts_next + OFFSET_BITS'(1);
              s.mode = S_DOT1; cons = 1'b0;
            end
          end
          S_CMT, S_CMT_STAR: begin
            if (eoi) begin
              if (s.diag == D_NONE) s.diag = D_OPEN_CMT;
              em = 1'b1; ek = K_BAD; ee = pos; s.mode = S_IDLE; cons = 1'b0;
            end else if ((s.mode == S_CMT_STAR) && (b == "/")) begin
              em = 1'b1; ek = K_COMMENT; ee = nx; s.mode = S_IDLE;
            end else begin
              s.mode = (b == "*") ? S_CMT_STAR : S_CMT;
            end
          end
          S_NUM: begin
            if (dig) begin
              if (((s.nflags & NF_LEAD0) != 0) && ((s.nflags & NF_SPLIT) == 0) &&
                  (b >= "8")) begin
                osp_next = pos;
                s.nflags = s.nflags | NF_SPLIT;
              end
              s.nflags = s.nflags & ~NF_ONE;
            end else if (bv && (b == ".")) s.mode = S_FRAC;
            else if (bv && ((b == "e") || (b == "E"))) s.mode = S_EXPA_SIGN;
            else if (((s.nflags & NF_LEAD0) != 0) && ((s.nflags & NF_ONE) != 0) &&
                     bv && ((b == "x") || (b == "X"))) s.mode = S_HEX;
            else begin
              s.pend_kind = K_DEC;
              if ((s.nflags & NF_LEAD0) != 0) begin
                if ((s.nflags & NF_SPLIT) != 0) begin
                  em = 1'b1; ek = K_OCT; ee = osp_next;
                  ts_next = osp_next;
                end else begin
                  s.pend_kind = K_OCT;
                end
              end
              s.nflags = '0; s.mode = S_SUF; cons = 1'b0;
            end
          end
          S_HEX: begin
            if (!hx) begin
              s.pend_kind = K_HEX; s.nflags = '0; s.mode = S_SUF; cons = 1'b0;
            end
          end
          S_SUF: begin
            if (((s.nflags & NF_LONG) == 0) && bv && ((b == "l") || (b == "L"))) begin
              s.nflags = s.nflags | NF_LONG;
              if ((s.nflags & NF_UNS) != 0) begin
                em = 1'b1; ek = s.pend_kind; ee = nx; s.mode = S_IDLE;
              end
            end else if (((s.nflags & NF_UNS) == 0) && bv &&
                         ((b == "u") || (b == "U"))) begin
              s.nflags = s.nflags | NF_UNS;
              if ((s.nflags & NF_LONG) != 0) begin
                em = 1'b1; ek = s.pend_kind; ee = nx; s.mode = S_IDLE;
              end
            end else begin
              em = 1'b1; ek = s.pend_kind; ee = pos; s.mode = S_IDLE; cons = 1'b0;
            end
          end
          S_FRAC: begin
            if (!dig) begin
              s.mode = S_AFTER_A; cons = 1'b0;
            end
          end
          S_EXPA_SIGN, S_EXPB_SIGN: begin
            s.nflags = '0;
            s.mode   = (s.mode == S_EXPA_SIGN) ? S_EXPA_DIG : S_EXPB_DIG;
            cons     = bv && ((b == "+") || (b == "-"));
          end
          S_EXPA_DIG, S_EXPB_DIG: begin
            if (dig) s.nflags = NF_DIGIT;
            else begin
              if ((s.nflags == '0) && (s.diag == D_NONE)) s.diag = D_EMPTY_EXP;
              s.mode = (s.mode == S_EXPA_DIG) ? S_AFTER_A : S_FSUF;
              cons = 1'b0;
            end
          end
          S_AFTER_A: begin
            if (bv && ((b == "e") || (b == "E"))) s.mode = S_EXPB_SIGN;
            else begin
              s.mode = S_FSUF; cons = 1'b0;
            end
          end
          S_FSUF: begin
            if (bv && ((b == "f") || (b == "F"))) begin
              em = 1'b1; ek = K_FLT; ee = nx; s.mode = S_IDLE;
            end else begin
              em = 1'b1; ek = K_FLT; ee = pos; s.mode = S_IDLE; cons = 1'b0;
            end
          end
          S_CH_OPEN: begin
            if (bv && (b == "\\")) begin
              s.esc_str = 1'b0; s.mode = S_ESC;
            end else begin
              s.mode = S_CH_CLOSE;
              if (nl || nul || eoi) begin
                if (s.diag == D_NONE) s.diag = D_OPEN_CHR;
                cons = 1'b0;
              end
            end
          end
          S_CH_CLOSE: begin
            if (bv && (b == "'")) begin
              em = 1'b1; ek = K_CHR; ee = nx; s.mode = S_IDLE;
            end else begin
              if (s.diag == D_NONE) s.diag = D_OPEN_CHR;
              em = 1'b1; ek = K_BAD; ee = pos; s.mode = S_IDLE; cons = 1'b0;
            end
          end
          S_STR: begin
            if (bv && (b == "\"")) begin
              em = 1'b1; ek = K_STR; ee = nx; s.mode = S_IDLE;
            end else if (bv && (b == "\\")) begin
              s.esc_str = 1'b1; s.mode = S_ESC;
            end else if (nl || nul || eoi) begin
              if (s.diag == D_NONE) s.diag = D_OPEN_STR;
              em = 1'b1; ek = K_BAD; ee = pos; s.mode = S_IDLE; cons = 1'b0;
            end
          end
          S_ESC: begin
            if (bv && ((b == "'") || (b == "\"") || (b == "?") || (b == "\\") ||
                       (b == "a") || (b == "b") || (b == "f") || (b == "n") ||
                       (b == "r") || (b == "t") || (b == "v"))) begin
              s.mode = ret;
            end else if (bv && (b == "x")) begin
              s.esc_cnt = 2'd0; s.mode = S_ESC_HEX;
            end else if (oct) begin
              s.esc_cnt = 2'd0; s.mode = S_ESC_OCT;
            end else begin
              if (s.diag == D_NONE) s.diag = D_BAD_ESC;
              s.mode = ret; cons = bv;
            end
          end
          S_ESC_OCT: begin
            if (oct) begin
              s.esc_cnt = s.esc_cnt + 2'd1;
              if (s.esc_cnt >= 2'd2) s.mode = ret;
            end else begin
              s.mode = ret; cons = 1'b0;
            end
          end
          S_ESC_HEX: begin
            if (hx) s.esc_cnt = 2'd1;
            else begin
              if ((s.esc_cnt == 2'd0) && (s.diag == D_NONE)) s.diag = D_EMPTY_HEX;
              s.mode = ret; cons = 1'b0;
            end
          end
          default: begin
            if (bv) begin
              ts_next  = pos;
              es       = pos;
              s.diag   = D_NONE;
              s.nflags = '0;
              if (direct_kind(b) != K_BAD) begin
                em = 1'b1; ek = direct_kind(b); ee = nx; s.mode = S_IDLE;
              end else if (b == ".") s.mode = S_DOT1;
              else if (single_kind(b) != K_BAD) begin
                s.held = b; s.mode = S_P1;
              end else if (b == "L") begin
                ib_next[0] = b; s.ilen = 4'd1; s.mode = S_LPRE;
              end else if (b == "'") s.mode = S_CH_OPEN;
              else if (b == "\"") s.mode = S_STR;
              else if (spc) s.mode = S_WS;
              else if (dig) begin
                s.nflags = ((b == "0") ? NF_LEAD0 : 4'd0) | NF_ONE;
                s.mode   = S_NUM;
              end else if (wrd) begin
                ib_next[0] = b; s.ilen = 4'd1; s.mode = S_IDENT;
              end else begin
                s.diag = D_ILLEGAL;
                em = 1'b1; ek = K_BAD; ee = nx; s.mode = S_IDLE;
              end
            end
          end
        endcase
        if (em && (cnt < 2'(REC_MAX))) begin
          wide_s = {32'b0, es};
          wide_e = {32'b0, ee};
          bnd.recs[cnt].kind      = (s.diag != D_NONE) ? K_BAD : ek;
          bnd.recs[cnt].start_off = wide_s[31:0];
          bnd.recs[cnt].end_off   = wide_e[31:0];
          bnd.recs[cnt].diag      = s.diag;
          bnd.recs[cnt].last      = 1'b0;
          cnt = cnt + 2'd1;
        end
        done = cons;
      end
    end
    bnd.cnt = cnt;
    if (cnt != 2'd0) bnd.recs[cnt - 2'd1].last = 1'b1;
    if (eoi) begin
      s        = '0;
      s.mode   = S_IDLE;
      ts_next  = '0;
      osp_next = '0;
      pos_next = '0;
    end else begin
      pos_next = nx;
    end
  end

  assign push      = accept && (cnt != 2'd0);
  assign push_data = bnd;

  always_ff @(posedge clk) begin
    if (rst) begin
      st  <= '{mode: S_IDLE, default: '0};
      ts  <= '0;
      osp <= '0;
      pos <= '0;
    end else if (accept) begin
      st  <= s;
      ts  <= ts_next;
      osp <= osp_next;
      pos <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) ib <= ib_next;
  end

endmodule

/* sv/cts_queue.sv */
// Small bundle queue between the scanner front end and the record serializer.
module cts_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  cts_pkg::bundle_t  push_data,
  output logic              full,
  input  logic              pop,
  output logic              nonempty,
  output cts_pkg::bundle_t  head
);
  import cts_pkg::*;

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  bundle_t         mem [DEPTH];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic [AW:0]     count;
  logic            do_pop;

  assign full     = (count == (AW+1)'(DEPTH));
  assign nonempty = (count != '0);
  assign head     = mem[rd_ptr];
  assign do_pop   = pop && nonempty;

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + AW'(1);
      if (do_pop) rd_ptr <= rd_ptr + AW'(1);
      count <= count + (AW+1)'(push) - (AW+1)'(do_pop);
    end
  end

endmodule

/* sv/cts_back.sv */
// Back end: takes bundles from the queue and sends their records one at a time.
module cts_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              nonempty,
  input  cts_pkg::bundle_t  head,
  output logic              pop,
  cts_out_if.source         tokens
);
  import cts_pkg::*;

  bundle_t     cur;
  logic        have;
  logic [1:0]  idx;
  logic        take;
  rec_t        rec;

  assign take = !have || (tokens.ready && (idx == (cur.cnt - 2'd1)));
  assign pop  = take && nonempty;
  assign rec  = cur.recs[idx];

  assign tokens.valid        = have;
  assign tokens.token_kind   = rec.kind;
  assign tokens.start_offset = rec.start_off;
  assign tokens.end_offset   = rec.end_off;
  assign tokens.diag_code    = rec.diag;
  assign tokens.last_of_run  = rec.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      have <= 1'b0;
      idx  <= 2'd0;
    end else if (take) begin
      have <= nonempty;
      idx  <= 2'd0;
    end else if (tokens.ready) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take && nonempty) cur <= head;
  end

endmodule

/* sv/c_token_scanner.sv */
// C token scanner: one source byte per item in, one token record per item out.
// Input channel bytes: char_code plus end_of_input; an end-of-input item closes
// the open token and restarts offsets at zero for the next source.
// Output channel tokens: kind, start/end byte offsets, first diagnostic, and
// last_of_run on the final record caused by one input item.
// The scanner state machine takes one byte per cycle; ready drops only when
// the four-entry bundle queue is full.
// A byte that completes tokens yields up to three records; they enter the
// queue together and leave one record per cycle while the receiver is ready,
// so the record path runs at one record per cycle and sustained input rate is
// one byte per cycle while bytes average at most one record each.
// When the queue is empty, a record is written into the bundle queue and then
// registered in the back end before it is shown on the output.
// Reset clears the scanner state, offsets and queue; no records are pending.
// When the receiver stalls, the current record holds, the queue fills, and
// then the input stalls; nothing is dropped.
module c_token_scanner #(
  parameter int OFFSET_BITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  cts_in_if.sink     bytes,
  cts_out_if.source  tokens
);
  import cts_pkg::*;

  logic     push, full, pop, nonempty;
  bundle_t  push_data, head;

  cts_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .bytes     (bytes),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  cts_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .nonempty  (nonempty),
    .head      (head)
  );

  cts_back u_back (
    .clk      (clk),
    .rst      (rst),
    .nonempty (nonempty),
    .head     (head),
    .pop      (pop),
    .tokens   (tokens)
  );

endmodule

/* sv/cts_checker.sv */
// Port-level checks for the C token scanner and their bind to the top level.
`include "assert_macros.svh"

module cts_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [6:0]  kind,
  input logic [31:0] start_off,
  input logic [31:0] end_off,
  input logic [2:0]  diag
);
  import cts_pkg::*;

  `CTS_ASSERT(a_valid_hold, clk, rst, out_valid && !out_ready |=> out_valid,
              "valid dropped while stalled")
  `CTS_ASSERT(a_data_hold, clk, rst,
              out_valid && !out_ready |=> $stable(kind) && $stable(start_off) &&
              $stable(end_off), "record changed while stalled")
  `CTS_ASSERT(a_bad_diag, clk, rst, out_valid |-> ((kind == K_BAD) == (diag != D_NONE)),
              "bad kind and diagnostic disagree")
  `CTS_ASSERT(a_nonempty, clk, rst, out_valid |-> (end_off != start_off), "empty token")
  `CTS_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !out_valid, "output valid after reset")
endmodule

bind c_token_scanner cts_checker u_cts_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (tokens.valid),
  .out_ready (tokens.ready),
  .kind      (tokens.token_kind),
  .start_off (tokens.start_offset),
  .end_off   (tokens.end_offset),
  .diag      (tokens.diag_code)
);

/* verif/c_token_scanner_tb.sv */
// Self-checking testbench for the C token scanner: byte stream in, token records out.
module c_token_scanner_tb;
  import cts_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [8:0] END_MARK = 9'h100;

  typedef struct {
    logic [7:0] ch;
    bit         eoi;
    bit         fixed;
    rec_t       want;
  } stim_t;

  logic clk = 1'b0;
  logic rst;
  always #6 clk = ~clk;

  cts_in_if  in_ch();
  cts_out_if out_ch();

  c_token_scanner dut (.clk(clk), .rst(rst), .bytes(in_ch), .tokens(out_ch));

  // scanner mirror
  mode_t       md;
  logic [31:0] tok_start, byte_pos, oct_split;
  logic [7:0]  held0, held1;
  logic [7:0]  ibuf [8];
  logic [3:0]  ilen;
  logic [2:0]  diag;
  logic [3:0]  nf;
  logic [1:0]  esc_cnt;
  logic [6:0]  pend_kind;
  bit          esc_str;
  rec_t        step_recs [$];

  rec_t  pending_tokens [$];
  stim_t stim [$];
  int    errors = 0, items_in = 0, recs_seen = 0, eoi_seen = 0;
  bit    quiet = 0, held_off = 0;

  string kw_names [32] = '{
    "auto", "break", "case", "char", "const", "continue", "default", "do",
    "double", "else", "enum", "extern", "float", "for", "goto", "if",
    "int", "long", "register", "return", "short", "signed", "sizeof",
    "static", "struct", "switch", "typedef", "union", "unsigned", "void",
    "volatile", "while"
  };

  function automatic bit is_dig(logic [8:0] c);
    return c >= "0" && c <= "9";
  endfunction
  function automatic bit is_oct(logic [8:0] c);
    return c >= "0" && c <= "7";
  endfunction
  function automatic bit is_alpha(logic [8:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction
  function automatic bit is_hexd(logic [8:0] c);
    return is_dig(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction
  function automatic bit is_space(logic [8:0] c);
    return c == " " || (c >= 9 && c <= 13);
  endfunction

  function automatic logic [6:0] lone_kind(logic [8:0] c);
    case (c)
      "-": return 7'd10;  "+": return 7'd13;  "&": return 7'd16;
      "*": return 7'd18;  "!": return 7'd21;  "/": return 7'd23;
      "%": return 7'd25;  "<": return 7'd29;  ">": return 7'd33;
      "=": return 7'd35;  "^": return 7'd37;  "|": return 7'd40;
      "#": return 7'd45;
      default: return K_BAD;
    endcase
  endfunction

  function automatic logic [7:0] joined_kind(logic [7:0] a, logic [8:0] b);
    case (a)
      "-": return b == ">" ? 8'd7 : b == "-" ? 8'd8 : b == "=" ? 8'd9 : 8'd0;
      "+": return b == "+" ? 8'd11 : b == "=" ? 8'd12 : 8'd0;
      "&": return b == "&" ? 8'd14 : b == "=" ? 8'd15 : 8'd0;
      "*": return b == "=" ? 8'd17 : 8'd0;
      "!": return b == "=" ? 8'd20 : 8'd0;
      "/": return b == "=" ? 8'd22 : 8'd0;
      "%": return b == "=" ? 8'd24 : 8'd0;
      "<": return b == "=" ? 8'd26 : b == "<" ? PAIR_MORE : 8'd0;
      ">": return b == "=" ? 8'd30 : b == ">" ? PAIR_MORE : 8'd0;
      "=": return b == "=" ? 8'd34 : 8'd0;
      "^": return b == "=" ? 8'd36 : 8'd0;
      "|": return b == "|" ? 8'd38 : b == "=" ? 8'd39 : 8'd0;
      "#": return b == "#" ? 8'd44 : 8'd0;
      default: return 8'd0;
    endcase
  endfunction

  function automatic logic [6:0] word_kind();
    string s;
    bit    hit;
    if (ilen > 8) return K_IDENT;
    for (int i = 0; i < 32; i++) begin
      s = kw_names[i];
      hit = (s.len() == ilen);
      for (int j = 0; j < s.len() && hit; j++)
        if (ibuf[j] != s[j]) hit = 0;
      if (hit) return K_KW0 + 7'(i);
    end
    return K_IDENT;
  endfunction

  function automatic void add_token(logic [6:0] k, logic [31:0] s, logic [31:0] e,
                                    logic [2:0] d);
    rec_t r;
    if (step_recs.size() >= REC_MAX) return;
    r.kind = k; r.start_off = s; r.end_off = e; r.diag = d; r.last = 1'b0;
    step_recs.push_back(r);
  endfunction

  function automatic void close_tok(logic [6:0] k, logic [31:0] e);
    add_token(diag != D_NONE ? K_BAD : k, tok_start, e, diag);
    md = S_IDLE;
  endfunction

  function automatic void note(logic [2:0] d);
    if (diag == D_NONE) diag = d;
  endfunction

  function automatic void scanner_clear();
    md = S_IDLE; tok_start = 0; byte_pos = 0; oct_split = 0;
    held0 = 0; held1 = 0; ilen = 0; diag = 0; nf = 0; esc_cnt = 0;
    pend_kind = 0; esc_str = 0;
    foreach (ibuf[i]) ibuf[i] = 0;
  endfunction

  function automatic bit open_token(logic [8:0] c, logic [31:0] p);
    logic [6:0] k;
    if (c == END_MARK) return 1;
    tok_start = p; diag = 0; nf = 0;
    case (c)
      "[": k = 7'd1;  "]": k = 7'd2;  "(": k = 7'd3;  ")": k = 7'd4;
      "~": k = 7'd19; "?": k = 7'd41; ":": k = 7'd42; ",": k = 7'd43;
      "{": k = 7'd46; "}": k = 7'd47; ";": k = 7'd48;
      default: k = K_BAD;
    endcase
    if (k != K_BAD) close_tok(k, p + 1);
    else if (c == ".") md = S_DOT1;
    else if (lone_kind(c) != K_BAD) begin held0 = c[7:0]; md = S_P1; end
    else if (c == "L") begin ibuf[0] = c[7:0]; ilen = 1; md = S_LPRE; end
    else if (c == "'") md = S_CH_OPEN;
    else if (c == "\"") md = S_STR;
    else if (is_space(c)) md = S_WS;
    else if (is_dig(c)) begin
      nf = (c == "0" ? NF_LEAD0 : 4'd0) | NF_ONE;
      md = S_NUM;
    end else if (is_alpha(c) || c == "_") begin
      ibuf[0] = c[7:0]; ilen = 1; md = S_IDENT;
    end else begin
      diag = D_ILLEGAL; close_tok(K_BAD, p + 1);
    end
    return 1;
  endfunction

  // returns 1 when the byte is used up
  function automatic bit scan_byte(logic [8:0] c, logic [31:0] p);
    logic [31:0] nx;
    logic [7:0]  k;
    mode_t       back;
    nx = p + 1;
    back = esc_str ? S_STR : S_CH_CLOSE;
    case (md)
      S_WS: begin
        if (is_space(c)) return 1;
        close_tok(K_WS, p); return 0;
      end
      S_IDENT: begin
        if (is_alpha(c) || is_dig(c) || c == "_") begin
          if (ilen < 8) ibuf[ilen] = c[7:0];
          if (ilen <= 8) ilen++;
          return 1;
        end
        close_tok(word_kind(), p); return 0;
      end
      S_LPRE: begin
        if (c == "'") begin md = S_CH_OPEN; return 1; end
        if (c == "\"") begin md = S_STR; return 1; end
        md = S_IDENT; return 0;
      end
      S_P1: begin
        if (held0 == "/" && c == "*") begin md = S_CMT; return 1; end
        k = joined_kind(held0, c);
        if (k == PAIR_MORE) begin held1 = c[7:0]; md = S_P2; return 1; end
        if (k != 0) begin close_tok(k[6:0], nx); return 1; end
        close_tok(lone_kind(held0), p); return 0;
      end
      S_P2: begin
        if (c == "=") begin close_tok(held0 == "<" ? K_SHL_EQ : K_SHR_EQ, nx); return 1; end
        close_tok(held0 == "<" ? K_SHL : K_SHR, p); return 0;
      end
      S_DOT1: begin
        if (c == ".") begin md = S_DOT2; return 1; end
        if (is_dig(c)) begin md = S_FRAC; return 0; end
        close_tok(K_PERIOD, p); return 0;
      end
      S_DOT2: begin
        if (c == ".") begin close_tok(K_ELLIPSIS, nx); return 1; end
        add_token(K_PERIOD, tok_start, tok_start + 1, D_NONE);
        tok_start = tok_start + 1;
        md = S_DOT1; return 0;
      end
      S_CMT, S_CMT_STAR: begin
        if (c == END_MARK) begin note(D_OPEN_CMT); close_tok(K_BAD, p); return 0; end
        if (md == S_CMT_STAR && c == "/") begin close_tok(K_COMMENT, nx); return 1; end
        md = (c == "*") ? S_CMT_STAR : S_CMT;
        return 1;
      end
      S_NUM: begin
        if (is_dig(c)) begin
          if ((nf & NF_LEAD0) != 0 && (nf & NF_SPLIT) == 0 && c >= "8") begin
            oct_split = p; nf |= NF_SPLIT;
          end
          nf &= ~NF_ONE;
          return 1;
        end
        if (c == ".") begin md = S_FRAC; return 1; end
        if (c == "e" || c == "E") begin md = S_EXPA_SIGN; return 1; end
        if ((nf & NF_LEAD0) != 0 && (nf & NF_ONE) != 0 && (c == "x" || c == "X")) begin
          md = S_HEX; return 1;
        end
        pend_kind = K_DEC;
        if ((nf & NF_LEAD0) != 0) begin
          if ((nf & NF_SPLIT) != 0) begin
            add_token(K_OCT, tok_start, oct_split, D_NONE);
            tok_start = oct_split;
          end else pend_kind = K_OCT;
        end
        nf = 0; md = S_SUF; return 0;
      end
      S_HEX: begin
        if (is_hexd(c)) return 1;
        pend_kind = K_HEX; nf = 0; md = S_SUF; return 0;
      end
      S_SUF: begin
        if ((nf & NF_LONG) == 0 && (c == "l" || c == "L")) nf |= NF_LONG;
        else if ((nf & NF_UNS) == 0 && (c == "u" || c == "U")) nf |= NF_UNS;
        else begin close_tok(pend_kind, p); return 0; end
        if ((nf & (NF_LONG | NF_UNS)) == (NF_LONG | NF_UNS)) close_tok(pend_kind, nx);
        return 1;
      end
      S_FRAC: begin
        if (is_dig(c)) return 1;
        md = S_AFTER_A; return 0;
      end
      S_EXPA_SIGN, S_EXPB_SIGN: begin
        nf = 0;
        md = (md == S_EXPA_SIGN) ? S_EXPA_DIG : S_EXPB_DIG;
        return c == "+" || c == "-";
      end
      S_EXPA_DIG, S_EXPB_DIG: begin
        if (is_dig(c)) begin nf = NF_DIGIT; return 1; end
        if (nf == 0) note(D_EMPTY_EXP);
        md = (md == S_EXPA_DIG) ? S_AFTER_A : S_FSUF;
        return 0;
      end
      S_AFTER_A: begin
        if (c == "e" || c == "E") begin md = S_EXPB_SIGN; return 1; end
        md = S_FSUF; return 0;
      end
      S_FSUF: begin
        if (c == "f" || c == "F") begin close_tok(K_FLT, nx); return 1; end
        close_tok(K_FLT, p); return 0;
      end
      S_CH_OPEN: begin
        if (c == "\\") begin esc_str = 0; md = S_ESC; return 1; end
        md = S_CH_CLOSE;
        if (c == 10 || c == 0 || c == END_MARK) begin note(D_OPEN_CHR); return 0; end
        return 1;
      end
      S_CH_CLOSE: begin
        if (c == "'") begin close_tok(K_CHR, nx); return 1; end
        note(D_OPEN_CHR); close_tok(K_BAD, p); return 0;
      end
      S_STR: begin
        if (c == "\"") begin close_tok(K_STR, nx); return 1; end
        if (c == "\\") begin esc_str = 1; md = S_ESC; return 1; end
        if (c == 10 || c == 0 || c == END_MARK) begin
          note(D_OPEN_STR); close_tok(K_BAD, p); return 0;
        end
        return 1;
      end
      S_ESC: begin
        case (c)
          "'", "\"", "?", "\\", "a", "b", "f", "n", "r", "t", "v": begin
            md = back; return 1;
          end
          "x": begin esc_cnt = 0; md = S_ESC_HEX; return 1; end
          default: begin
            if (is_oct(c)) begin esc_cnt = 0; md = S_ESC_OCT; return 1; end
            note(D_BAD_ESC); md = back; return c != END_MARK;
          end
        endcase
      end
      S_ESC_OCT: begin
        if (is_oct(c)) begin
          esc_cnt = esc_cnt + 1;
          if (esc_cnt >= 2) md = back;
          return 1;
        end
        md = back; return 0;
      end
      S_ESC_HEX: begin
        if (is_hexd(c)) begin esc_cnt = 1; return 1; end
        if (esc_cnt == 0) note(D_EMPTY_HEX);
        md = back; return 0;
      end
      default: return open_token(c, p);
    endcase
  endfunction

  function automatic void scanner_step(logic [7:0] ch, bit eoi);
    logic [8:0] c;
    c = eoi ? END_MARK : {1'b0, ch};
    step_recs.delete();
    for (int g = 0; g < 16; g++)
      if (scan_byte(c, byte_pos)) break;
    if (eoi) scanner_clear();
    else byte_pos = byte_pos + 1;
    if (step_recs.size() > 0) step_recs[step_recs.size() - 1].last = 1'b1;
  endfunction

  // stimulus building
  function automatic void add_text(string s);
    stim_t t;
    for (int i = 0; i < s.len(); i++) begin
      t.ch = s[i]; t.eoi = 0; t.fixed = 0; t.want = '0;
      stim.push_back(t);
    end
  endfunction

  function automatic void add_row(logic [7:0] ch, bit eoi, bit fixed, logic [6:0] k,
                                  logic [31:0] s, logic [31:0] e, logic [2:0] d);
    stim_t t;
    t.ch = ch; t.eoi = eoi; t.fixed = fixed;
    t.want.kind = k; t.want.start_off = s; t.want.end_off = e;
    t.want.diag = d; t.want.last = 1'b1;
    stim.push_back(t);
  endfunction

  function automatic string pick(string set);
    string s;
    s = " ";
    s[0] = set[$urandom_range(0, set.len() - 1)];
    return s;
  endfunction

  function automatic string run_of(string set, int lo, int hi);
    string s;
    int    n;
    s = "";
    n = $urandom_range(lo, hi);
    repeat (n) s = {s, pick(set)};
    return s;
  endfunction

  function automatic void add_fragment();
    string  s;
    string  esc_tbl [8];
    stim_t  t;
    esc_tbl = '{"\\n", "\\x", "\\x4f", "\\101", "\\7", "\\q", "\\\"", "\\\\"};
    case ($urandom_range(0, 11))
      0, 1: begin
        if ($urandom_range(0, 1)) s = kw_names[$urandom_range(0, 31)];
        else s = {pick("abcxyzLE_"), run_of("abcdefghijklmnopqrstuvwxyz_019", 0, 11)};
      end
      2, 3: begin
        case ($urandom_range(0, 6))
          0: s = run_of("0123456789", 1, 5);
          1: s = {"0", run_of("01234567899", 0, 5)};
          2: s = {"0", pick("xX"), run_of("0123456789abcdefABCDEF", 0, 4)};
          3: s = {run_of("0123456789", 0, 3), ".", run_of("0123456789", 0, 3)};
          4: s = {run_of("0123456789", 1, 3), pick("eE"), pick("+-1"), run_of("0123", 0, 2)};
          5: s = {".", run_of("0123456789", 1, 3), "e", run_of("12", 0, 1), "e",
                  run_of("3", 0, 1), pick("fF;")};
          default: s = {run_of("0123456789", 1, 3), run_of("uUlL", 0, 3)};
        endcase
      end
      4: begin
        s = "\"";
        repeat ($urandom_range(0, 4))
          s = {s, $urandom_range(0, 2) ? pick("abc ?'") : esc_tbl[$urandom_range(0, 7)]};
        s = {s, $urandom_range(0, 5) ? "\"" : "\n"};
        if ($urandom_range(0, 1)) s = {"L", s};
      end
      5: begin
        s = {"'", $urandom_range(0, 1) ? pick("ab\"") : esc_tbl[$urandom_range(0, 7)],
             run_of("'b\n", 0, 1)};
        if ($urandom_range(0, 2)) s = {s, "'"};
      end
      6: s = {"/*", run_of("ab*/ ", 0, 6), "*/"};
      7, 8: s = run_of("[](){}.-><=&|+*!/%^#~?:,;", 1, 4);
      9: s = run_of(" \t\n\v\f\r", 1, 3);
      10: begin
        t.ch = 8'($urandom_range(0, 255)); t.eoi = 0; t.fixed = 0; t.want = '0;
        stim.push_back(t);
        return;
      end
      default: begin
        t.ch = 8'($urandom_range(0, 255)); t.eoi = 1; t.fixed = 0; t.want = '0;
        stim.push_back(t);
        return;
      end
    endcase
    add_text(s);
  endfunction

  // source side
  initial begin
    int idx;
    rst = 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.char_code <= 8'd0;
    in_ch.end_of_input <= 1'b0;

    add_row("[", 0, 1, 7'd1, 0, 1, D_NONE);
    add_row(8'hFF, 0, 1, K_BAD, 1, 2, D_ILLEGAL);
    add_row(8'h00, 0, 1, K_BAD, 2, 3, D_ILLEGAL);
    add_row(8'h80, 0, 1, K_BAD, 3, 4, D_ILLEGAL);
    add_row(8'h00, 1, 0, K_BAD, 0, 0, D_NONE);
    add_text("/**/");
    add_text("/*");
    add_row(8'h00, 1, 1, K_BAD, 4, 6, D_OPEN_CMT);
    add_text("0789L>>=..1e+ '\\q'\"\\x\"");
    add_text("unsigned volatiles sizeof");
    add_row(8'h7F, 1, 0, K_BAD, 0, 0, D_NONE);
    while (stim.size() < 220) add_fragment();
    add_row(8'h00, 1, 0, K_BAD, 0, 0, D_NONE);

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    for (idx = 0; idx < stim.size(); idx++) begin
      if (idx > stim.size() - 40) quiet = 1;
      if (!quiet && $urandom_range(0, 4) == 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      in_ch.valid <= 1'b1;
      in_ch.char_code <= stim[idx].ch;
      in_ch.end_of_input <= stim[idx].eoi;
      @(posedge clk);
      while (!in_ch.ready) @(posedge clk);
    end
    in_ch.valid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Scanned %0d items (%0d end-of-input marks), checked %0d token records.",
             items_in, eoi_seen, recs_seen);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  // sink side
  initial begin
    out_ch.ready <= 1'b0;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (!held_off && items_in >= 80) begin
        held_off = 1;
        out_ch.ready <= 1'b0;
        repeat (150) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  // input side: predict
  always @(posedge clk) begin
    stim_t t;
    if (rst) scanner_clear();
    else if (in_ch.valid && in_ch.ready) begin
      t = stim[items_in];
      items_in++;
      if (in_ch.end_of_input) eoi_seen++;
      scanner_step(in_ch.char_code, in_ch.end_of_input);
      if (t.fixed) begin
        step_recs.delete();
        step_recs.push_back(t.want);
      end
      foreach (step_recs[i]) pending_tokens.push_back(step_recs[i]);
    end
  end

  // output side: compare
  always @(posedge clk) begin
    rec_t w;
    if (!rst && out_ch.valid && out_ch.ready) begin
      recs_seen++;
      if (pending_tokens.size() == 0) begin
        $error("unexpected token record kind=%0d start=%0d",
               out_ch.token_kind, out_ch.start_offset);
        errors++;
      end else begin
        w = pending_tokens.pop_front();
        if (out_ch.token_kind !== w.kind) begin
          $error("token_kind expected %0d got %0d", w.kind, out_ch.token_kind); errors++;
        end
        if (out_ch.start_offset !== w.start_off) begin
          $error("start_offset expected %0d got %0d", w.start_off, out_ch.start_offset);
          errors++;
        end
        if (out_ch.end_offset !== w.end_off) begin
          $error("end_offset expected %0d got %0d", w.end_off, out_ch.end_offset); errors++;
        end
        if (out_ch.diag_code !== w.diag) begin
          $error("diag_code expected %0d got %0d", w.diag, out_ch.diag_code); errors++;
        end
        if (out_ch.last_of_run !== w.last) begin
          $error("last_of_run expected %0d got %0d", w.last, out_ch.last_of_run); errors++;
        end
      end
    end
  end

  initial begin
    #3_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
